@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/sfpu_pkg.sv @@
package sfpu_pkg;

	// CORDIC depth; stages beyond the arctangent table are not built.
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NUM_STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	// Internal widths.
	localparam int ANG_W = 34;
	localparam int XY_W = 34;
	localparam int VDT_W = 33;
	localparam int DZ_W = 33;
	localparam int ZP_W = 50;
	localparam int PR_W = 50;
	localparam int SUM_W = 57;

	// Angle constants at LSB 2^-28 rad and the CORDIC start value at LSB 2^-30.
	localparam logic signed [ANG_W-1:0] PI_Q28 = ANG_W'(843314857);
	localparam logic signed [ANG_W-1:0] TWO_PI_Q28 = ANG_W'(1686629714);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = ANG_W'(421657428);
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(652032874);

	// Arctangent of 2^-i at LSB 2^-28 rad.
	localparam logic signed [31:0] ATAN_Q28 [ATAN_ENTRIES] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
		32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
		32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
		32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
		32'sd256, 32'sd128, 32'sd64, 32'sd32
	};

	// Configuration register indexes.
	localparam logic REG_STEP_TIME = 1'b0;
	localparam logic REG_INV_TAU = 1'b1;

	typedef struct packed {
		logic [1:0] leg_number;
		logic signed [15:0] foot_x;
		logic signed [15:0] foot_y;
		logic signed [15:0] foot_z;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] turn_rate;
		logic signed [15:0] body_height;
	} req_t;

	typedef struct packed {
		logic [1:0] leg_tag;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic signed [15:0] new_z;
		logic clipped;
	} rsp_t;

	// Data that rides along the CORDIC pipeline untouched.
	typedef struct packed {
		logic [1:0] tag;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic signed [VDT_W-1:0] vxdt;
		logic signed [VDT_W-1:0] vydt;
		logic signed [ZP_W-1:0] zp;
		logic flip;
	} cord_side_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] z;
		cord_side_t side;
	} cord_in_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		cord_side_t side;
	} cord_out_t;

endpackage

@@ src/stance_foot_position_update.sv @@
// Channel   Direction  Handshake             Payload
// config    in         psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
// req       in         req_valid/req_stall   req_data (req_t)
// rsp       out        rsp_valid/rsp_stall   rsp_data (rsp_t)
//
// One request is taken per cycle while req_stall is low; each gives one response
// after 3 front stages, one stage per CORDIC iteration, 4 stages of multiply, sum and round.
// The depth is set by the CORDIC iteration chain, one register stage per iteration.
// Reset is asynchronous and active low; it empties the pipeline and loads the
// register defaults. Every stage holds its item under a stall and empty stages
// keep filling, so requests keep entering behind a waiting response until every
// stage is full; from then on req_stall follows rsp_stall in the same cycle.
`include "assert_macros.svh"

module stance_foot_position_update import sfpu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic req_valid,
	output logic req_stall,
	input req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_data
);

	// Round to LSB 2^-13 and saturate to 16 bits; the top bit is the clip flag.
	function automatic logic [16:0] round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-31:0] r;
		logic [16:0] res;
		r = v[SUM_W-1:30];
		if (r > (SUM_W-30)'(32767)) begin
			res = {1'b1, 16'h7FFF};
		end else if (r < -(SUM_W-30)'(32768)) begin
			res = {1'b1, 16'h8000};
		end else begin
			res = {1'b0, r[15:0]};
		end
		return res;
	endfunction

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << 29);

	logic [15:0] step_time_q;
	logic [15:0] inv_tau_q;
	logic signed [16:0] dt_sx;
	logic signed [16:0] itau_sx;
	logic cfg_wr;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd655;
			inv_tau_q <= 16'd12800;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_STEP_TIME: step_time_q <= pwdata[15:0];
				REG_INV_TAU: inv_tau_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back; misaligned addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_STEP_TIME: prdata = {16'd0, step_time_q};
				REG_INV_TAU: prdata = {16'd0, inv_tau_q};
				default: prdata = '0;
			endcase
		end
	end

	assign dt_sx = signed'({1'b0, step_time_q});
	assign itau_sx = signed'({1'b0, inv_tau_q});

	// Pipeline control: a stage loads when empty or when its item moves on.
	logic v_s1, v_s2, v_s3, v_b1, v_b2, v_b3, v_b4;
	logic ready_s1, ready_s2, ready_s3, ready_b1, ready_b2, ready_b3, ready_b4;
	logic cord_in_ready;
	logic cord_out_valid;
	cord_in_t cord_in;
	cord_out_t cord_out;

	assign ready_b4 = !v_b4 || !rsp_stall;
	assign ready_b3 = !v_b3 || ready_b4;
	assign ready_b2 = !v_b2 || ready_b3;
	assign ready_b1 = !v_b1 || ready_b2;
	assign ready_s3 = !v_s3 || cord_in_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign req_stall = !ready_s1;
	assign rsp_valid = v_b4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= req_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_b1) v_b1 <= cord_out_valid;
			if (ready_b2) v_b2 <= v_b1;
			if (ready_b3) v_b3 <= v_b2;
			if (ready_b4) v_b4 <= v_b3;
		end
	end

	// Stage 1: angle and velocity products, height error.
	logic [1:0] tag_s1;
	logic signed [15:0] fx_s1, fy_s1, fz_s1;
	logic signed [ANG_W-1:0] theta_s1;
	logic signed [VDT_W-1:0] vxdt_s1, vydt_s1;
	logic signed [16:0] dh_s1;
	logic signed [VDT_W-1:0] yaw_dt;

	assign yaw_dt = VDT_W'(req_data.turn_rate) * VDT_W'(dt_sx);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			tag_s1 <= req_data.leg_number;
			fx_s1 <= req_data.foot_x;
			fy_s1 <= req_data.foot_y;
			fz_s1 <= req_data.foot_z;
			theta_s1 <= -ANG_W'(yaw_dt);
			vxdt_s1 <= VDT_W'(req_data.vel_x) * VDT_W'(dt_sx);
			vydt_s1 <= VDT_W'(req_data.vel_y) * VDT_W'(dt_sx);
			dh_s1 <= 17'(req_data.body_height) - 17'(req_data.foot_z);
		end
	end

	// Stage 2: wrap the angle into [-pi, pi]; height error times 1/tau.
	logic [1:0] tag_s2;
	logic signed [15:0] fx_s2, fy_s2, fz_s2;
	logic signed [ANG_W-1:0] theta_s2;
	logic signed [VDT_W-1:0] vxdt_s2, vydt_s2;
	logic signed [DZ_W-1:0] dzp_s2;
	logic signed [ANG_W-1:0] wrap_c;

	always_comb begin
		if (theta_s1 > PI_Q28) begin
			wrap_c = theta_s1 - TWO_PI_Q28;
		end else if (theta_s1 < -PI_Q28) begin
			wrap_c = theta_s1 + TWO_PI_Q28;
		end else begin
			wrap_c = theta_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			tag_s2 <= tag_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;
			theta_s2 <= wrap_c;
			vxdt_s2 <= vxdt_s1;
			vydt_s2 <= vydt_s1;
			dzp_s2 <= DZ_W'(dh_s1) * DZ_W'(itau_sx);
		end
	end

	// Stage 3: fold into [-pi/2, pi/2] and note the sign flip; times dt.
	logic [1:0] tag_s3;
	logic signed [15:0] fx_s3, fy_s3, fz_s3;
	logic signed [ANG_W-1:0] z_s3;
	logic flip_s3;
	logic signed [VDT_W-1:0] vxdt_s3, vydt_s3;
	logic signed [ZP_W-1:0] zp_s3;
	logic signed [ANG_W-1:0] fold_c;
	logic flip_c;

	always_comb begin
		if (theta_s2 > HALF_PI_Q28) begin
			fold_c = theta_s2 - PI_Q28;
			flip_c = 1'b1;
		end else if (theta_s2 < -HALF_PI_Q28) begin
			fold_c = theta_s2 + PI_Q28;
			flip_c = 1'b1;
		end else begin
			fold_c = theta_s2;
			flip_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			tag_s3 <= tag_s2;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
			z_s3 <= fold_c;
			flip_s3 <= flip_c;
			vxdt_s3 <= vxdt_s2;
			vydt_s3 <= vydt_s2;
			zp_s3 <= ZP_W'(dzp_s2) * ZP_W'(dt_sx);
		end
	end

	// Sine and cosine.
	assign cord_in = '{z: z_s3, side: '{tag: tag_s3, fx: fx_s3, fy: fy_s3, fz: fz_s3,
		vxdt: vxdt_s3, vydt: vydt_s3, zp: zp_s3, flip: flip_s3}};

	sfpu_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.in_ready(cord_in_ready),
		.in_data(cord_in),
		.out_valid(cord_out_valid),
		.out_ready(ready_b1),
		.out_data(cord_out)
	);

	// Stage B1: undo the fold on cosine and sine; form the z sum.
	logic [1:0] tag_b1;
	logic signed [15:0] fx_b1, fy_b1;
	logic signed [XY_W-1:0] c_b1, s_b1;
	logic signed [VDT_W-1:0] vxdt_b1, vydt_b1;
	logic signed [SUM_W-1:0] sz_b1;

	always_ff @(posedge clk) begin
		if (ready_b1) begin
			tag_b1 <= cord_out.side.tag;
			fx_b1 <= cord_out.side.fx;
			fy_b1 <= cord_out.side.fy;
			c_b1 <= cord_out.side.flip ? -cord_out.x : cord_out.x;
			s_b1 <= cord_out.side.flip ? -cord_out.y : cord_out.y;
			vxdt_b1 <= cord_out.side.vxdt;
			vydt_b1 <= cord_out.side.vydt;
			sz_b1 <= (SUM_W'(cord_out.side.fz) <<< 30) + (SUM_W'(cord_out.side.zp) <<< 6);
		end
	end

	// Stage B2: rotation products.
	logic [1:0] tag_b2;
	logic signed [PR_W-1:0] cfx_b2, sfy_b2, sfx_b2, cfy_b2;
	logic signed [VDT_W-1:0] vxdt_b2, vydt_b2;
	logic signed [SUM_W-1:0] sz_b2;

	always_ff @(posedge clk) begin
		if (ready_b2) begin
			tag_b2 <= tag_b1;
			cfx_b2 <= PR_W'(c_b1) * PR_W'(fx_b1);
			sfy_b2 <= PR_W'(s_b1) * PR_W'(fy_b1);
			sfx_b2 <= PR_W'(s_b1) * PR_W'(fx_b1);
			cfy_b2 <= PR_W'(c_b1) * PR_W'(fy_b1);
			vxdt_b2 <= vxdt_b1;
			vydt_b2 <= vydt_b1;
			sz_b2 <= sz_b1;
		end
	end

	// Stage B3: sums at LSB 2^-43 plus the rounding half.
	logic [1:0] tag_b3;
	logic signed [SUM_W-1:0] sum_x_b3, sum_y_b3, sum_z_b3;

	always_ff @(posedge clk) begin
		if (ready_b3) begin
			tag_b3 <= tag_b2;
			sum_x_b3 <= SUM_W'(cfx_b2) - SUM_W'(sfy_b2) - (SUM_W'(vxdt_b2) <<< 14) + ROUND_HALF;
			sum_y_b3 <= SUM_W'(sfx_b2) + SUM_W'(cfy_b2) - (SUM_W'(vydt_b2) <<< 14) + ROUND_HALF;
			sum_z_b3 <= sz_b2 + ROUND_HALF;
		end
	end

	// Stage B4: round, saturate and present the response.
	logic [16:0] rx_c, ry_c, rz_c;

	assign rx_c = round_sat(sum_x_b3);
	assign ry_c = round_sat(sum_y_b3);
	assign rz_c = round_sat(sum_z_b3);

	always_ff @(posedge clk) begin
		if (ready_b4) begin
			rsp_data.leg_tag <= tag_b3;
			rsp_data.new_x <= rx_c[15:0];
			rsp_data.new_y <= ry_c[15:0];
			rsp_data.new_z <= rz_c[15:0];
			rsp_data.clipped <= rx_c[16] | ry_c[16] | rz_c[16];
		end
	end

	`ASSERT_NXT(a_req_enter, req_valid && !req_stall, v_s1, "accepted request did not enter stage 1")
	`ASSERT_NXT(a_b3_hold, v_b3 && !ready_b3, v_b3 && $stable(sum_x_b3), "stalled sum stage lost its item")
	`ASSERT_NXT(a_cfg_dt, cfg_wr && (paddr[2] == REG_STEP_TIME), step_time_q == $past(pwdata[15:0]), "step time write not taken")

endmodule

@@ src/sfpu_cordic.sv @@
`include "assert_macros.svh"

module sfpu_cordic import sfpu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cord_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output cord_out_t out_data
);

	logic [NUM_STAGES-1:0] v_s;
	logic [NUM_STAGES-1:0] ready;
	logic signed [XY_W-1:0] x_s [NUM_STAGES];
	logic signed [XY_W-1:0] y_s [NUM_STAGES];
	logic signed [ANG_W-1:0] z_s [NUM_STAGES];
	cord_side_t side_s [NUM_STAGES];

	// One rotation-mode iteration per register stage.
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		logic signed [XY_W-1:0] xi;
		logic signed [XY_W-1:0] yi;
		logic signed [ANG_W-1:0] zi;
		cord_side_t si;
		logic vi;
		logic signed [XY_W-1:0] xn;
		logic signed [XY_W-1:0] yn;
		logic signed [ANG_W-1:0] zn;

		if (k == 0) begin : g_first
			assign xi = CORDIC_GAIN_Q30;
			assign yi = '0;
			assign zi = in_data.z;
			assign si = in_data.side;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
			assign si = side_s[k-1];
			assign vi = v_s[k-1];
		end

		// A stage may load when it is empty or its content moves on.
		if (k == NUM_STAGES - 1) begin : g_last
			assign ready[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign ready[k] = !v_s[k] || ready[k+1];
		end

		// Rotate toward zero residual angle; shifts round toward minus infinity.
		always_comb begin
			if (!zi[ANG_W-1]) begin
				xn = xi - (yi >>> k);
				yn = yi + (xi >>> k);
				zn = zi - ANG_W'(ATAN_Q28[k]);
			end else begin
				xn = xi + (yi >>> k);
				yn = yi - (xi >>> k);
				zn = zi + ANG_W'(ATAN_Q28[k]);
			end
		end

		always_ff @(posedge clk) begin
			if (ready[k]) begin
				x_s[k] <= xn;
				y_s[k] <= yn;
				z_s[k] <= zn;
				side_s[k] <= si;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ready[k]) begin
				v_s[k] <= vi;
			end
		end
	end

	assign in_ready = ready[0];
	assign out_valid = v_s[NUM_STAGES-1];
	assign out_data = '{x: x_s[NUM_STAGES-1], y: y_s[NUM_STAGES-1], side: side_s[NUM_STAGES-1]};

	`ASSERT_NXT(a_cord_enter, in_valid && in_ready, v_s[0], "accepted item did not enter the CORDIC")
	`ASSERT_NXT(a_cord_hold, out_valid && !out_ready, out_valid && $stable(x_s[NUM_STAGES-1]), "stalled CORDIC output moved")

endmodule
